// ----- design/gvfe_pkg.sv -----
// Shared types, constants and the control store of the group value frame encoder.
// No dependencies; every other file of the block imports this package.
package gvfe_pkg;

    // Request beat
    typedef struct packed {
        logic [15:0]        group_address;
        logic [7:0]         main_type;
        logic [7:0]         sub_type;
        logic               value_valid;
        logic signed [31:0] value_number;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [15:0] dest_address;
        logic [2:0]  frame_length;
        logic [7:0]  apdu_byte0;
        logic [7:0]  apdu_byte1;
        logic [7:0]  apdu_byte2;
        logic [7:0]  apdu_byte3;
        logic        type_unsupported;
        logic        range_error;
    } out_item_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_CODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_CODE  = 1'd1;
    localparam int CODE_W = 4;
    localparam logic [CODE_W-1:0] WRITE_CODE_RST = 4'd2;
    localparam logic [CODE_W-1:0] READ_CODE_RST  = 4'd0;

    // Datapoint type numbers
    localparam logic [7:0] DPT_SWITCH = 8'd1;
    localparam logic [7:0] DPT_BYTE   = 8'd5;
    localparam logic [7:0] DPT_FLOAT  = 8'd9;
    localparam logic [7:0] SUB_PERCENT = 8'd1;
    localparam logic [7:0] SUB_ANGLE   = 8'd3;

    // Frame lengths
    localparam logic [2:0] LEN_HEADER = 3'd2;
    localparam logic [2:0] LEN_BYTE   = 3'd3;
    localparam logic [2:0] LEN_FLOAT  = 3'd4;

    // Scaling divider: magnitude of value * 255 is 40 bits, two quotient bits a step
    localparam int PROD_W    = 40;
    localparam int DIVR_W    = 9;
    localparam int REM_W     = DIVR_W + 1;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [DIVR_W-1:0] DIVISOR_PERCENT = 9'd100;
    localparam logic [DIVR_W-1:0] DIVISOR_ANGLE   = 9'd360;

    // Float packing
    localparam int EXP_W = 5;
    localparam logic [EXP_W-1:0] EXP_LAST = 5'd15;
    localparam logic [EXP_W-1:0] EXP_OVER = 5'd16;
    localparam logic [11:0] MANT_MAX = 12'h7FF;
    localparam logic [11:0] MANT_MIN = 12'h800;

    // Datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
    localparam logic [OP_W-1:0] OP_PREP = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd2;
    localparam logic [OP_W-1:0] OP_NORM = 3'd3;
    localparam logic [OP_W-1:0] OP_EMIT = 3'd4;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_NEED_DIV  = 3'd1;
    localparam logic [COND_W-1:0] C_NEED_NORM = 3'd2;
    localparam logic [COND_W-1:0] C_DIV_MORE  = 3'd3;
    localparam logic [COND_W-1:0] C_NORM_MORE = 3'd4;

    localparam int PC_W = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              last;
    } ctrl_word_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic need_div;
        logic need_norm;
        logic div_more;
        logic norm_more;
    } status_t;

    // Control store
    function automatic ctrl_word_t ucode_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            3'd0:    w = '{op: OP_PREP, cond: C_NEED_DIV,  target: 3'd3, last: 1'b0};
            3'd1:    w = '{op: OP_NOP,  cond: C_NEED_NORM, target: 3'd5, last: 1'b0};
            3'd2:    w = '{op: OP_EMIT, cond: C_NEVER,     target: 3'd0, last: 1'b1};
            3'd3:    w = '{op: OP_DIV,  cond: C_DIV_MORE,  target: 3'd3, last: 1'b0};
            3'd4:    w = '{op: OP_EMIT, cond: C_NEVER,     target: 3'd0, last: 1'b1};
            3'd5:    w = '{op: OP_NORM, cond: C_NORM_MORE, target: 3'd5, last: 1'b0};
            3'd6:    w = '{op: OP_EMIT, cond: C_NEVER,     target: 3'd0, last: 1'b1};
            default: w = '{op: OP_EMIT, cond: C_NEVER,     target: 3'd0, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ----- design/gvfe_sequencer.sv -----
// Step counter of the frame encoder: fetches control words and resolves jumps.
// Depends on gvfe_pkg for the control store and the status struct.
module gvfe_sequencer
    import gvfe_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            launch,
    input  status_t         status,
    output logic            busy,
    output logic [OP_W-1:0] op
);

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      word;
    logic            taken;

    assign word = ucode_word(pc_reg);

    // Evaluate the jump condition of the current word
    always_comb
    begin
        case (word.cond)
            C_NEVER:     taken = 1'b0;
            C_NEED_DIV:  taken = status.need_div;
            C_NEED_NORM: taken = status.need_norm;
            C_DIV_MORE:  taken = status.div_more;
            C_NORM_MORE: taken = status.norm_more;
            default:     taken = 1'b0;
        endcase
    end

    // Advance the step counter, stop after the last word
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (busy_reg)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
                pc_next   = '0;
            end
            else if (taken)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
        else if (launch)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;
    assign op   = busy_reg ? word.op : OP_NOP;

endmodule

// ----- design/gvfe_datapath.sv -----
// Datapath of the frame encoder: request hold, scaling divider, float normalizer
// and result register. Depends on gvfe_pkg; driven by gvfe_sequencer.
module gvfe_datapath
    import gvfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  in_item_t          item,
    input  logic [OP_W-1:0]   op,
    input  logic [CODE_W-1:0] write_code,
    input  logic [CODE_W-1:0] read_code,
    output status_t           status,
    output out_item_t         result,
    output logic              result_valid
);

    in_item_t           item_reg;
    logic signed [31:0] mant_reg, mant_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic [DIVR_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]  qd_reg, qd_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    out_item_t          result_reg, result_next;
    logic               result_valid_reg;

    logic               is_float;
    logic               is_scaled;
    logic [DIVR_W-1:0]  divisor;
    logic [31:0]        mag;
    logic [PROD_W-1:0]  product;
    logic signed [31:0] mant_shift;
    logic [REM_W-1:0]   div_rem;
    logic [PROD_W-1:0]  div_qd;

    function automatic logic out_of_range(input logic signed [31:0] x);
        return !((&x[31:11]) || !(|x[31:11]));
    endfunction

    // Classify the held request
    assign is_float  = item_reg.value_valid && (item_reg.main_type == DPT_FLOAT);
    assign is_scaled = item_reg.value_valid && (item_reg.main_type == DPT_BYTE) &&
                       ((item_reg.sub_type == SUB_PERCENT) || (item_reg.sub_type == SUB_ANGLE));
    assign divisor   = (item_reg.sub_type == SUB_PERCENT) ? DIVISOR_PERCENT : DIVISOR_ANGLE;

    // Magnitude times 255 as shift and subtract
    assign mag     = item_reg.value_number[31] ? 32'(-item_reg.value_number)
                                               : 32'(item_reg.value_number);
    assign product = {mag, 8'd0} - {8'd0, mag};

    assign mant_shift = {mant_reg[31], mant_reg[31:1]};

    assign status.need_div  = is_scaled;
    assign status.need_norm = is_float && out_of_range(item_reg.value_number);
    assign status.div_more  = (cnt_reg != DCNT_W'(DIV_STEPS - 1));
    assign status.norm_more = out_of_range(mant_shift) && (exp_reg != EXP_LAST);

    // Restoring divide, two quotient bits per step
    always_comb
    begin
        logic [REM_W-1:0]  r;
        logic [PROD_W-1:0] q;
        r = {1'b0, rem_reg};
        q = qd_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r = {r[REM_W-2:0], q[PROD_W-1]};
            q = {q[PROD_W-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r    = r - {1'b0, divisor};
                q[0] = 1'b1;
            end
        end
        div_rem = r;
        div_qd  = q;
    end

    // Step the working registers as the control word says
    always_comb
    begin
        mant_next = mant_reg;
        exp_next  = exp_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        cnt_next  = cnt_reg;
        case (op)
            OP_PREP:
            begin
                mant_next = item_reg.value_number;
                exp_next  = '0;
                rem_next  = '0;
                qd_next   = product;
                cnt_next  = '0;
            end
            OP_DIV:
            begin
                rem_next = div_rem[DIVR_W-1:0];
                qd_next  = div_qd;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_NORM:
            begin
                mant_next = mant_shift;
                exp_next  = exp_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Assemble the frame
    always_comb
    begin
        logic [CODE_W-1:0] code;
        logic [7:0]        qbyte;
        logic              sat;
        logic [11:0]       m12;
        logic [3:0]        e4;
        code  = item_reg.value_valid ? write_code : read_code;
        qbyte = item_reg.value_number[31] ? 8'(-qd_reg[7:0]) : qd_reg[7:0];
        sat   = (exp_reg == EXP_OVER);
        m12   = sat ? (item_reg.value_number[31] ? MANT_MIN : MANT_MAX) : mant_reg[11:0];
        e4    = sat ? EXP_LAST[3:0] : exp_reg[3:0];

        result_next                  = '0;
        result_next.dest_address     = item_reg.group_address;
        result_next.frame_length     = LEN_HEADER;
        result_next.apdu_byte0       = {6'd0, code[3:2]};
        result_next.apdu_byte1       = {code[1:0], 6'd0};
        if (item_reg.value_valid)
        begin
            case (item_reg.main_type)
                DPT_SWITCH:
                begin
                    result_next.apdu_byte1[0] = (item_reg.value_number == 32'sd1);
                end
                DPT_BYTE:
                begin
                    result_next.frame_length = LEN_BYTE;
                    result_next.apdu_byte2   = is_scaled ? qbyte : item_reg.value_number[7:0];
                end
                DPT_FLOAT:
                begin
                    result_next.frame_length = LEN_FLOAT;
                    result_next.apdu_byte2   = {m12[11], e4, m12[10:8]};
                    result_next.apdu_byte3   = m12[7:0];
                    result_next.range_error  = sat;
                end
                default:
                begin
                    result_next.type_unsupported = 1'b1;
                end
            endcase
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        mant_reg <= mant_next;
        exp_reg  <= exp_next;
        rem_reg  <= rem_next;
        qd_reg   <= qd_next;
        cnt_reg  <= cnt_next;
        if (op == OP_EMIT)
        begin
            result_reg <= result_next;
        end
    end

    // Strobe one cycle per emitted frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= (op == OP_EMIT);
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ----- design/group_value_frame_encoder_core.sv -----
// Top level of the group value frame encoder: configuration registers,
// sequencer and datapath. Depends on gvfe_pkg, gvfe_sequencer, gvfe_datapath.
//
// Usage:
//   Request channel: drive item and pulse start while busy is low; the beat is
//   taken at that edge and busy rises for the duration of the work.
//   Result channel: result_valid strobes for exactly one cycle with the frame
//   on result. The receiver cannot stall; sample it in that cycle.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 write code, 1 read
//   code) and cfg_data; cfg_ready is always high. Write only while idle.
// Work sequence, from the accepting edge to the result strobe:
//   read requests, switch, raw byte and unknown types: prepare, check, then emit;
//   percent/angle scaling: prepare, then the divider that retires two
//   quotient bits of the 40-bit product per step (20 steps), then emit;
//   two-byte float: prepare, check, then n normalizer steps if needed (n at most
//   16, one arithmetic shift per step), then emit.
//   The next request can be taken the cycle after busy falls, while the result of
//   the previous one is still on its strobe.
// Reset: codes return to write 2 and read 0, the sequencer goes idle and no
//   strobe is raised.
module group_value_frame_encoder_core
    import gvfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]      cfg_data,
    output out_item_t              result,
    output logic                   result_valid
);

    logic [CODE_W-1:0] write_code_reg, write_code_next;
    logic [CODE_W-1:0] read_code_reg, read_code_next;
    logic              launch;
    logic [OP_W-1:0]   op;
    status_t           status;

    assign cfg_ready = 1'b1;
    assign launch    = start && !busy;

    // Decode register writes
    always_comb
    begin
        write_code_next = write_code_reg;
        read_code_next  = read_code_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WRITE_CODE: write_code_next = cfg_data;
                REG_READ_CODE:  read_code_next  = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_code_reg <= WRITE_CODE_RST;
            read_code_reg  <= READ_CODE_RST;
        end
        else
        begin
            write_code_reg <= write_code_next;
            read_code_reg  <= read_code_next;
        end
    end

    gvfe_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .status (status),
        .busy   (busy),
        .op     (op)
    );

    gvfe_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (launch),
        .item         (item),
        .op           (op),
        .write_code   (write_code_reg),
        .read_code    (read_code_reg),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

    // A strobe only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // Every finished request gives a strobe
    a_busy_end_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("request finished without result");

    // Saturated floats carry the top exponent
    a_sat_exponent: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.range_error) |-> (result.apdu_byte2[6:3] == 4'hF))
        else $error("range error without saturated exponent");

    // Unsupported types send the header only
    a_unsup_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.type_unsupported) |-> (result.frame_length == LEN_HEADER))
        else $error("unsupported type with payload bytes");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for group_value_frame_encoder_core: drives request and config beats,
// predicts every frame and compares it field by field. Depends on gvfe_pkg and the core.

module tb;
    import gvfe_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam longint FLOAT_MANT_TOP    = 2047;
    localparam longint FLOAT_MANT_BOTTOM = -2048;
    localparam int FLOAT_EXP_TOP = 15;

    typedef enum logic [1:0] {JOB_REQUEST, JOB_CONFIG, JOB_DRAIN} job_kind_e;

    typedef struct {
        job_kind_e                kind;
        in_item_t                 req;
        logic [CFG_INDEX_W-1:0]   reg_index;
        logic [CODE_W-1:0]        code;
    } job_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    in_item_t               item = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]      cfg_data = '0;
    out_item_t              result;
    logic                   result_valid;

    job_t      request_plan[$];
    out_item_t frames_due[$];
    logic [CODE_W-1:0] write_code_now = WRITE_CODE_RST;
    logic [CODE_W-1:0] read_code_now  = READ_CODE_RST;
    int fault_count = 0;
    int idle_span = 0;
    int burst_left = 1;
    int gap_left = 0;

    group_value_frame_encoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Build the expected frame for one request under the given service codes
    function automatic out_item_t encode_frame(input in_item_t r, input logic [CODE_W-1:0] wr,
                                               input logic [CODE_W-1:0] rd);
        out_item_t f;
        logic [CODE_W-1:0] code;
        longint v;
        longint m;
        int shifts;
        logic [11:0] mant;
        f = '0;
        f.dest_address = r.group_address;
        f.frame_length = LEN_HEADER;
        code = r.value_valid ? wr : rd;
        f.apdu_byte0 = {6'd0, code[3:2]};
        f.apdu_byte1 = {code[1:0], 6'd0};
        v = $signed(r.value_number);
        if (r.value_valid) begin
            if (r.main_type == DPT_SWITCH) begin
                f.apdu_byte1[0] = (v == 1);
            end else if (r.main_type == DPT_BYTE) begin
                f.frame_length = LEN_BYTE;
                // scale with exact product, truncate toward zero
                if (r.sub_type == SUB_PERCENT)
                    m = (v * 255) / 100;
                else if (r.sub_type == SUB_ANGLE)
                    m = (v * 255) / 360;
                else
                    m = v;
                f.apdu_byte2 = m[7:0];
            end else if (r.main_type == DPT_FLOAT) begin
                f.frame_length = LEN_FLOAT;
                // normalize by flooring shifts until the mantissa fits 12 bits
                m = v;
                shifts = 0;
                while (m > FLOAT_MANT_TOP || m < FLOAT_MANT_BOTTOM) begin
                    m = m >>> 1;
                    shifts++;
                end
                if (shifts > FLOAT_EXP_TOP) begin
                    shifts = FLOAT_EXP_TOP;
                    m = (v < 0) ? FLOAT_MANT_BOTTOM : FLOAT_MANT_TOP;
                    f.range_error = 1'b1;
                end
                mant = m[11:0];
                f.apdu_byte2 = {mant[11], shifts[3:0], mant[10:8]};
                f.apdu_byte3 = mant[7:0];
            end else begin
                f.type_unsupported = 1'b1;
            end
        end
        return f;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    task automatic queue_request(input logic [15:0] addr, input logic [7:0] main_t,
                                 input logic [7:0] sub_t, input logic vld,
                                 input logic signed [31:0] num);
        job_t j;
        j.kind = JOB_REQUEST;
        j.req.group_address = addr;
        j.req.main_type = main_t;
        j.req.sub_type = sub_t;
        j.req.value_valid = vld;
        j.req.value_number = num;
        j.reg_index = '0;
        j.code = '0;
        request_plan.push_back(j);
    endtask

    task automatic queue_config(input logic [CFG_INDEX_W-1:0] idx, input logic [CODE_W-1:0] code);
        job_t j;
        j.kind = JOB_CONFIG;
        j.req = '0;
        j.reg_index = idx;
        j.code = code;
        request_plan.push_back(j);
    endtask

    task automatic queue_drain();
        job_t j;
        j.kind = JOB_DRAIN;
        j.req = '0;
        j.reg_index = '0;
        j.code = '0;
        request_plan.push_back(j);
    endtask

    // Random request, weighted toward the encoded types
    task automatic queue_random_request();
        logic [7:0] main_t;
        logic [7:0] sub_t;
        logic signed [31:0] num;
        int pick;
        sub_t = 8'($urandom);
        num = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 4) begin
            main_t = DPT_SWITCH;
            if ($urandom_range(0, 1) == 1)
                num = 32'($urandom_range(0, 2)) - 32'd1;
        end else if (pick < 10) begin
            main_t = DPT_BYTE;
            case ($urandom_range(0, 2))
                0: sub_t = SUB_PERCENT;
                1: sub_t = SUB_ANGLE;
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1)
                num = 32'($urandom_range(0, 2000)) - 32'd1000;
        end else if (pick < 17) begin
            main_t = DPT_FLOAT;
            if ($urandom_range(0, 3) == 0) begin
                // land near a mantissa boundary at some exponent
                num = ($urandom_range(0, 1) == 1) ? 32'sd2047 : -32'sd2048;
                num = (num <<< $urandom_range(0, 20)) + 32'($urandom_range(0, 2)) - 32'd1;
            end else begin
                num = $signed($urandom) >>> $urandom_range(0, 31);
            end
        end else begin
            main_t = 8'($urandom);
        end
        queue_request(16'($urandom), main_t, sub_t, $urandom_range(0, 6) != 0, num);
    endtask

    // Driver: present request and config beats from the plan, in bursts with gaps
    always @(posedge clk)
    begin : drive_requests
        logic item_taken;
        logic hold_start;
        logic hold_cfg;
        logic quiet;
        if (rst_n) begin
            item_taken = start && !busy;
            hold_start = start && !item_taken;
            hold_cfg = cfg_valid && !cfg_ready;
            quiet = !item_taken && !busy && frames_due.size() == 0;
            if (item_taken) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            if (!hold_start && !hold_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_plan.size() != 0) begin
                    case (request_plan[0].kind)
                        JOB_REQUEST:
                        begin
                            hold_start = 1'b1;
                            item <= request_plan[0].req;
                            void'(request_plan.pop_front());
                        end
                        JOB_CONFIG:
                        begin
                            // write registers only once every frame is back
                            if (quiet) begin
                                hold_cfg = 1'b1;
                                cfg_index <= request_plan[0].reg_index;
                                cfg_data <= request_plan[0].code;
                                void'(request_plan.pop_front());
                            end
                        end
                        JOB_DRAIN:
                        begin
                            if (quiet)
                                void'(request_plan.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
            start <= hold_start;
            cfg_valid <= hold_cfg;
        end
    end

    // Monitor: track codes, predict on accepted requests, check each result beat
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WRITE_CODE: write_code_now = cfg_data;
                    REG_READ_CODE:  read_code_now = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: frame with nothing expected, actual %p", $time, result);
                    fault_count++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("dest_address", 32'(want.dest_address), 32'(result.dest_address));
                    check_field("frame_length", 32'(want.frame_length), 32'(result.frame_length));
                    check_field("apdu_byte0", 32'(want.apdu_byte0), 32'(result.apdu_byte0));
                    check_field("apdu_byte1", 32'(want.apdu_byte1), 32'(result.apdu_byte1));
                    check_field("apdu_byte2", 32'(want.apdu_byte2), 32'(result.apdu_byte2));
                    check_field("apdu_byte3", 32'(want.apdu_byte3), 32'(result.apdu_byte3));
                    check_field("type_unsupported", 32'(want.type_unsupported),
                                32'(result.type_unsupported));
                    check_field("range_error", 32'(want.range_error), 32'(result.range_error));
                end
            end
            if (start && !busy)
                frames_due.push_back(encode_frame(item, write_code_now, read_code_now));
            if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
                idle_span = 0;
            else
                idle_span++;
        end
    end

    initial
    begin : run_control
        logic [CODE_W-1:0] wr_set;
        logic [CODE_W-1:0] rd_set;
        // directed: read requests, switch, scaling, float edges, unknown types
        queue_request(16'h0000, DPT_FLOAT, 8'h00, 1'b0, 32'd12345);
        queue_request(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 32'hFFFF_FFFF);
        queue_request(16'h1234, DPT_SWITCH, 8'h01, 1'b1, 32'd1);
        queue_request(16'h4321, DPT_SWITCH, 8'h00, 1'b1, 32'd0);
        queue_request(16'hAAAA, DPT_SWITCH, 8'h00, 1'b1, 32'hFFFF_FFFF);
        queue_request(16'h5555, DPT_SWITCH, 8'h00, 1'b1, 32'h8000_0001);
        queue_request(16'h0101, DPT_BYTE, SUB_PERCENT, 1'b1, 32'd100);
        queue_request(16'h0202, DPT_BYTE, SUB_PERCENT, 1'b1, -32'sd100);
        queue_request(16'h0303, DPT_BYTE, SUB_PERCENT, 1'b1, 32'h7FFF_FFFF);
        queue_request(16'h0404, DPT_BYTE, SUB_PERCENT, 1'b1, 32'h8000_0000);
        queue_request(16'h0505, DPT_BYTE, SUB_ANGLE, 1'b1, 32'd360);
        queue_request(16'h0606, DPT_BYTE, SUB_ANGLE, 1'b1, 32'h8000_0000);
        queue_request(16'h0707, DPT_BYTE, SUB_ANGLE, 1'b1, 32'h7FFF_FFFF);
        queue_request(16'h0808, DPT_BYTE, 8'h00, 1'b1, 32'h1234_5678);
        queue_request(16'h0909, DPT_BYTE, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        queue_request(16'h1000, DPT_FLOAT, 8'h00, 1'b1, 32'd0);
        queue_request(16'h1001, DPT_FLOAT, 8'h01, 1'b1, 32'd2047);
        queue_request(16'h1002, DPT_FLOAT, 8'h02, 1'b1, -32'sd2048);
        queue_request(16'h1003, DPT_FLOAT, 8'h03, 1'b1, 32'd2048);
        queue_request(16'h1004, DPT_FLOAT, 8'h04, 1'b1, -32'sd2049);
        queue_request(16'h1005, DPT_FLOAT, 8'h05, 1'b1, 32'd67076096);
        queue_request(16'h1006, DPT_FLOAT, 8'h06, 1'b1, 32'd67108864);
        queue_request(16'h1007, DPT_FLOAT, 8'h07, 1'b1, -32'sd67108865);
        queue_request(16'h1008, DPT_FLOAT, 8'h08, 1'b1, 32'h7FFF_FFFF);
        queue_request(16'h1009, DPT_FLOAT, 8'h09, 1'b1, 32'h8000_0000);
        queue_request(16'h2000, 8'h00, SUB_PERCENT, 1'b1, 32'd1);
        queue_request(16'h2001, 8'hFF, 8'h00, 1'b1, 32'd77);

        // random phases, each under its own pair of service codes
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0:
                begin
                    wr_set = 4'hF;
                    rd_set = 4'hF;
                end
                1:
                begin
                    wr_set = 4'h0;
                    rd_set = 4'h0;
                end
                2:
                begin
                    wr_set = 4'hF;
                    rd_set = 4'h0;
                end
                3:
                begin
                    wr_set = 4'h0;
                    rd_set = 4'hF;
                end
                default:
                begin
                    wr_set = 4'($urandom);
                    rd_set = 4'($urandom);
                end
            endcase
            queue_config(REG_WRITE_CODE, wr_set);
            queue_config(REG_READ_CODE, rd_set);
            for (int n = 0; n < 48; n++) begin
                if (n == 24)
                    queue_drain();
                queue_random_request();
            end
        end

        // hold reset, then release on an edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while ((request_plan.size() != 0 || start || cfg_valid || frames_due.size() != 0)
               && idle_span < STALL_LIMIT)
            @(posedge clk);

        if (idle_span >= STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("tb: done, errors");
        end else begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (frames_due.size() != 0) begin
                $display("%0t: %0d expected frames never arrived", $time, frames_due.size());
                fault_count++;
            end
            if (fault_count == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
        end
        $finish;
    end

endmodule
